// ===== src/slex_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source lexer package
// Token kinds, error codes, result record and character classification.
// ----------------------------------------------------------------------------
package slex_pkg;

  localparam logic [6:0] K_IDENT    = 7'd41;
  localparam logic [6:0] K_STRING   = 7'd42;
  localparam logic [6:0] K_BIN      = 7'd43;
  localparam logic [6:0] K_OCT      = 7'd44;
  localparam logic [6:0] K_DEC      = 7'd45;
  localparam logic [6:0] K_HEX      = 7'd46;
  localparam logic [6:0] K_KEYWORD0 = 7'd47;
  localparam logic [6:0] K_EOF      = 7'd68;
  localparam logic [6:0] K_ERROR    = 7'd69;
  localparam logic [6:0] K_SLASH    = 7'd15;
  localparam logic [6:0] K_SLASH_EQ = 7'd16;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNTERM_STR = 2'd1;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd2;

  localparam int KW_COUNT = 21;

  typedef struct packed {
    logic [6:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic [15:0] col;
    logic [1:0]  err;
  } token_t;

  typedef struct packed {
    logic       valid;
    logic       has_a;
    logic [7:0] a_ch;
    logic [6:0] a_kind;
    logic       has_b;
    logic [7:0] b_ch;
    logic [6:0] b_kind;
    logic [6:0] single;
  } op_info_t;

  typedef logic [63:0] kw_word_t;
  localparam kw_word_t KW_WORD [KW_COUNT] = '{
    64'("and"), 64'("break"), 64'("case"), 64'("class"), 64'("continue"),
    64'("default"), 64'("else"), 64'("false"), 64'("for"), 64'("fun"),
    64'("if"), 64'("null"), 64'("or"), 64'("debug"), 64'("return"),
    64'("super"), 64'("switch"), 64'("this"), 64'("true"), 64'("var"),
    64'("while")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd4, 4'd5, 4'd8, 4'd7, 4'd4, 4'd5, 4'd3, 4'd3, 4'd2,
    4'd4, 4'd2, 4'd5, 4'd6, 4'd5, 4'd6, 4'd4, 4'd4, 4'd3, 4'd5
  };

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {["a":"z"], ["A":"Z"]}) || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_octal(input logic [7:0] c);
    return c inside {["0":"7"]};
  endfunction

  function automatic logic is_hexd(input logic [7:0] c);
    return c inside {["0":"9"], ["a":"f"], ["A":"F"]};
  endfunction

  function automatic logic [6:0] word_kind(input logic [63:0] p, input logic [3:0] n);
    logic [6:0] k;
    k = K_IDENT;
    if (n <= 4'd8) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (KW_LEN[i] == n && KW_WORD[i] == p) k = K_KEYWORD0 + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic op_info_t op_info(input logic [7:0] c);
    op_info_t o;
    o = '0;
    o.valid = 1'b1;
    case (c)
      "(": o.single = 7'd0;
      ")": o.single = 7'd1;
      "{": o.single = 7'd2;
      "}": o.single = 7'd3;
      "[": o.single = 7'd4;
      "]": o.single = 7'd5;
      ";": o.single = 7'd6;
      ",": o.single = 7'd7;
      ".": o.single = 7'd8;
      "-": o = '{1'b1, 1'b1, "-", 7'd10, 1'b1, "=", 7'd11, 7'd9};
      "+": o = '{1'b1, 1'b1, "+", 7'd13, 1'b1, "=", 7'd14, 7'd12};
      "/": o = '{1'b1, 1'b1, "=", K_SLASH_EQ, 1'b0, 8'd0, 7'd0, K_SLASH};
      "*": o = '{1'b1, 1'b1, "=", 7'd18, 1'b0, 8'd0, 7'd0, 7'd17};
      "~": o = '{1'b1, 1'b1, "=", 7'd20, 1'b0, 8'd0, 7'd0, 7'd19};
      "^": o = '{1'b1, 1'b1, "=", 7'd22, 1'b0, 8'd0, 7'd0, 7'd21};
      "&": o = '{1'b1, 1'b1, "=", 7'd24, 1'b0, 8'd0, 7'd0, 7'd23};
      "|": o = '{1'b1, 1'b1, "=", 7'd26, 1'b0, 8'd0, 7'd0, 7'd25};
      "%": o = '{1'b1, 1'b1, "=", 7'd28, 1'b0, 8'd0, 7'd0, 7'd27};
      "?": o.single = 7'd29;
      ":": o.single = 7'd30;
      "!": o = '{1'b1, 1'b1, "=", 7'd32, 1'b0, 8'd0, 7'd0, 7'd31};
      "=": o = '{1'b1, 1'b1, "=", 7'd34, 1'b0, 8'd0, 7'd0, 7'd33};
      "<": o = '{1'b1, 1'b1, "=", 7'd36, 1'b1, "<", 7'd37, 7'd35};
      ">": o = '{1'b1, 1'b1, "=", 7'd39, 1'b1, ">", 7'd40, 7'd38};
      default: o.valid = 1'b0;
    endcase
    return o;
  endfunction

endpackage

// ===== src/source_lexer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source lexer top level
// Scanning: a byte is judged when the next byte or the end mark arrives, and
// its tokens enter the result queue when that transaction is accepted.
// Throughput: one byte per cycle; one token leaves per cycle unless out_stall
// is high, from a 4-entry result queue; input stalls if under three are free.
// Reset: synchronous; scanner state, queue and file number are cleared.
// ----------------------------------------------------------------------------
module source_lexer_top #(
  parameter int OFFSET_WIDTH = 24,
  parameter int LINE_WIDTH   = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  token_kind,
  output logic [23:0] start_offset,
  output logic [23:0] lexeme_length,
  output logic [19:0] line_number,
  output logic [15:0] column_number,
  output logic [7:0]  source_file,
  output logic [1:0]  error_kind,
  output logic        last_of_run
);
  import slex_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_LINECOM, M_BLOCK, M_BLOCK_SKIP, M_BLOCK_END, M_STRING,
    M_STRING_SKIP, M_OP2, M_BIN, M_OCT, M_HEX, M_DEC, M_FRAC, M_PRE_B, M_PRE_X
  } mode_t;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX  = {OFFSET_WIDTH{1'b1}};
  localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};

  mode_t                   mode, mode_next;
  logic                    la_valid, la_valid_next;
  logic [7:0]              la_byte, la_byte_next;
  logic [OFFSET_WIDTH-1:0] cur_off, cur_off_next;
  logic [OFFSET_WIDTH-1:0] tok_start, tok_start_next;
  logic [LINE_WIDTH-1:0]   line_cnt, line_cnt_next;
  logic [15:0]             col_cnt, col_cnt_next;
  logic [63:0]             wprefix, wprefix_next;
  logic [3:0]              wlen, wlen_next;
  logic [7:0]              file_number;

  token_t     q_tok [4];
  logic [3:0] q_last;
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] q_count;

  token_t     res [3];
  logic [1:0] nres;
  logic       accept, pop;

  function automatic token_t mk(input logic [6:0] k, input logic [OFFSET_WIDTH-1:0] s,
                                input logic [OFFSET_WIDTH-1:0] l,
                                input logic [LINE_WIDTH-1:0] ln, input logic [15:0] cl,
                                input logic [1:0] e);
    token_t t;
    t.kind  = k;
    t.start = 24'(s);
    t.len   = 24'(l);
    t.line  = 20'(ln);
    t.col   = cl;
    t.err   = e;
    return t;
  endfunction

  assign in_stall  = q_count > 3'd1;
  assign accept    = in_valid && !in_stall;
  assign out_valid = q_count != 3'd0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    logic [7:0]  c;
    logic [8:0]  n;
    logic        n_dig, reidle;
    token_t      e1, e2, e3, e4;
    logic        v1, v2, v3, v4;
    op_info_t    op;
    mode_next      = mode;
    la_valid_next  = la_valid;
    la_byte_next   = la_byte;
    cur_off_next   = cur_off;
    tok_start_next = tok_start;
    line_cnt_next  = line_cnt;
    col_cnt_next   = col_cnt;
    wprefix_next   = wprefix;
    wlen_next      = wlen;
    c      = la_byte;
    n      = end_of_source ? 9'h100 : {1'b0, char_code};
    n_dig  = !n[8] && is_digit(n[7:0]);
    reidle = 1'b0;
    op     = op_info(c);
    e1 = '0; e2 = '0; e3 = '0; e4 = '0;
    v1 = 1'b0; v2 = 1'b0; v3 = 1'b0; v4 = 1'b0;
    res[0] = '0; res[1] = '0; res[2] = '0;
    nres = 2'd0;

    if (la_valid) begin
      case (mode_next)
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
            if (wlen_next < 4'd8) wprefix_next = {wprefix_next[55:0], c};
            if (wlen_next < 4'd9) wlen_next = wlen_next + 4'd1;
          end else begin
            e1 = mk(word_kind(wprefix_next, wlen_next), tok_start_next,
                    cur_off_next - tok_start_next, line_cnt_next, col_cnt_next, ERR_NONE);
            v1 = 1'b1; reidle = 1'b1;
          end
        end
        M_BIN, M_OCT, M_HEX, M_DEC, M_FRAC: begin
          logic       cont;
          logic [6:0] k;
          case (mode_next)
            M_BIN:   begin cont = c == "0" || c == "1"; k = K_BIN; end
            M_OCT:   begin cont = is_octal(c); k = K_OCT; end
            M_HEX:   begin cont = is_hexd(c); k = K_HEX; end
            default: begin cont = is_digit(c); k = K_DEC; end
          endcase
          if (cont) begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
          end else if (mode_next == M_DEC && c == "." && n_dig) begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
            mode_next = M_FRAC;
          end else begin
            e1 = mk(k, tok_start_next, cur_off_next - tok_start_next, line_cnt_next,
                    col_cnt_next, ERR_NONE);
            v1 = 1'b1; reidle = 1'b1;
          end
        end
        M_PRE_B, M_PRE_X, M_BLOCK_SKIP, M_BLOCK_END, M_STRING_SKIP: begin
          if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
          case (mode_next)
            M_PRE_B:      mode_next = M_BIN;
            M_PRE_X:      mode_next = M_HEX;
            M_BLOCK_SKIP: mode_next = M_BLOCK;
            M_STRING_SKIP: mode_next = M_STRING;
            default:      mode_next = M_IDLE;
          endcase
        end
        M_LINECOM: begin
          if (c != "\n") begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
          end else begin
            reidle = 1'b1;
          end
        end
        M_BLOCK: begin
          if (c == "*" && n == {1'b0, "/"}) begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
            mode_next = M_BLOCK_END;
          end else if (c == "\n") begin
            if (line_cnt_next != LINE_MAX) line_cnt_next = line_cnt_next + 1'b1;
            col_cnt_next = 16'd2;
          end else begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            logic [OFFSET_WIDTH-1:0] len;
            len = cur_off_next - tok_start_next;
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
            if (cur_off_next != OFF_MAX) len = len + 1'b1;
            e1 = mk(K_STRING, tok_start_next, len, line_cnt_next, col_cnt_next, ERR_NONE);
            v1 = 1'b1;
            mode_next = M_IDLE;
          end else if (c == "\n") begin
            if (line_cnt_next != LINE_MAX) line_cnt_next = line_cnt_next + 1'b1;
            col_cnt_next = 16'd2;
          end else begin
            if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
            if (c == "\\" && (n == {1'b0, "\\"} || n == {1'b0, "\""}))
              mode_next = M_STRING_SKIP;
          end
        end
        M_OP2: mode_next = M_IDLE;
        default: reidle = 1'b1;
      endcase

      if (reidle) begin
        mode_next      = M_IDLE;
        tok_start_next = cur_off_next;
        if (c == "\n") begin
          if (line_cnt_next != LINE_MAX) line_cnt_next = line_cnt_next + 1'b1;
          col_cnt_next = 16'd2;
        end else begin
          if (col_cnt_next != 16'hFFFF) col_cnt_next = col_cnt_next + 16'd1;
          if (c == " " || c == "\r" || c == "\t") begin
            mode_next = M_IDLE;
          end else if (c == "#") begin
            mode_next = M_LINECOM;
          end else if (is_letter(c)) begin
            wprefix_next = {56'd0, c};
            wlen_next    = 4'd1;
            mode_next    = M_IDENT;
          end else if (is_digit(c)) begin
            if (c == "0" && n == {1'b0, "b"}) mode_next = M_PRE_B;
            else if (c == "0" && !n[8] && is_octal(n[7:0])) mode_next = M_OCT;
            else if (c == "0" && n == {1'b0, "x"}) mode_next = M_PRE_X;
            else mode_next = M_DEC;
          end else if (c == "/" && n == {1'b0, "/"}) begin
            mode_next = M_LINECOM;
          end else if (c == "/" && n == {1'b0, "*"}) begin
            mode_next = M_BLOCK_SKIP;
          end else if (c == "\"") begin
            mode_next = M_STRING;
          end else if (op.valid) begin
            v2 = 1'b1;
            if (op.has_a && n == {1'b0, op.a_ch}) begin
              e2 = mk(op.a_kind, cur_off_next, OFFSET_WIDTH'(2), line_cnt_next,
                      col_cnt_next, ERR_NONE);
              mode_next = M_OP2;
            end else if (op.has_b && n == {1'b0, op.b_ch}) begin
              e2 = mk(op.b_kind, cur_off_next, OFFSET_WIDTH'(2), line_cnt_next,
                      col_cnt_next, ERR_NONE);
              mode_next = M_OP2;
            end else begin
              e2 = mk(op.single, cur_off_next, OFFSET_WIDTH'(1), line_cnt_next,
                      col_cnt_next, ERR_NONE);
            end
          end else begin
            v2 = 1'b1;
            e2 = mk(K_ERROR, cur_off_next, OFFSET_WIDTH'(1), line_cnt_next,
                    col_cnt_next, ERR_UNEXPECTED);
          end
        end
      end
      if (cur_off_next != OFF_MAX) cur_off_next = cur_off_next + 1'b1;
    end

    if (end_of_source) begin
      v3 = 1'b1;
      case (mode_next)
        M_IDENT: e3 = mk(word_kind(wprefix_next, wlen_next), tok_start_next,
                         cur_off_next - tok_start_next, line_cnt_next, col_cnt_next,
                         ERR_NONE);
        M_BIN: e3 = mk(K_BIN, tok_start_next, cur_off_next - tok_start_next,
                       line_cnt_next, col_cnt_next, ERR_NONE);
        M_OCT: e3 = mk(K_OCT, tok_start_next, cur_off_next - tok_start_next,
                       line_cnt_next, col_cnt_next, ERR_NONE);
        M_HEX: e3 = mk(K_HEX, tok_start_next, cur_off_next - tok_start_next,
                       line_cnt_next, col_cnt_next, ERR_NONE);
        M_DEC, M_FRAC: e3 = mk(K_DEC, tok_start_next, cur_off_next - tok_start_next,
                               line_cnt_next, col_cnt_next, ERR_NONE);
        M_STRING, M_STRING_SKIP: e3 = mk(K_ERROR, tok_start_next,
                                         cur_off_next - tok_start_next, line_cnt_next,
                                         col_cnt_next, ERR_UNTERM_STR);
        default: v3 = 1'b0;
      endcase
      v4 = 1'b1;
      e4 = mk(K_EOF, cur_off_next, '0, line_cnt_next, col_cnt_next, ERR_NONE);
      mode_next      = M_IDLE;
      la_valid_next  = 1'b0;
      la_byte_next   = 8'd0;
      cur_off_next   = '0;
      tok_start_next = '0;
      line_cnt_next  = LINE_WIDTH'(1);
      col_cnt_next   = 16'd1;
      wprefix_next   = '0;
      wlen_next      = 4'd0;
    end else begin
      la_byte_next  = char_code;
      la_valid_next = 1'b1;
    end

    if (v1) begin res[nres] = e1; nres = nres + 2'd1; end
    if (v2) begin res[nres] = e2; nres = nres + 2'd1; end
    if (v3 && nres != 2'd3) begin res[nres] = e3; nres = nres + 2'd1; end
    if (v4 && nres != 2'd3) begin res[nres] = e4; nres = nres + 2'd1; end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      la_valid    <= 1'b0;
      la_byte     <= 8'd0;
      cur_off     <= '0;
      tok_start   <= '0;
      line_cnt    <= LINE_WIDTH'(1);
      col_cnt     <= 16'd1;
      wprefix     <= '0;
      wlen        <= 4'd0;
      file_number <= 8'd0;
      rd_ptr      <= 2'd0;
      wr_ptr      <= 2'd0;
      q_count     <= 3'd0;
    end else begin
      if (cfg_write) file_number <= cfg_data;
      if (accept) begin
        mode      <= mode_next;
        la_valid  <= la_valid_next;
        la_byte   <= la_byte_next;
        cur_off   <= cur_off_next;
        tok_start <= tok_start_next;
        line_cnt  <= line_cnt_next;
        col_cnt   <= col_cnt_next;
        wprefix   <= wprefix_next;
        wlen      <= wlen_next;
        for (int i = 0; i < 3; i++) begin
          if (2'(i) < nres) begin
            q_tok[wr_ptr + 2'(i)]  <= res[i];
            q_last[wr_ptr + 2'(i)] <= (2'(i) == nres - 2'd1);
          end
        end
        wr_ptr <= wr_ptr + nres;
      end
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      q_count <= q_count + (accept ? {1'b0, nres} : 3'd0) - {2'd0, pop};
    end
  end

  assign token_kind    = q_tok[rd_ptr].kind;
  assign start_offset  = q_tok[rd_ptr].start;
  assign lexeme_length = q_tok[rd_ptr].len;
  assign line_number   = q_tok[rd_ptr].line;
  assign column_number = q_tok[rd_ptr].col;
  assign error_kind    = q_tok[rd_ptr].err;
  assign last_of_run   = q_last[rd_ptr];
  assign source_file   = file_number;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source lexer testbench
// Sends short source texts byte by byte, each closed by an end mark, and
// predicts the token stream in the testbench itself. Every received token is
// compared field by field with the oldest predicted one. The run goes through
// several idle and stall patterns and several file number settings.
// ----------------------------------------------------------------------------
module tb_top;
  import slex_pkg::*;

  localparam int LIMIT = 400000;
  localparam logic [8:0] NO_NEXT = 9'h100;
  localparam logic [8:0] NO_PAIR = 9'h1FF;

  typedef enum int {
    S_IDLE, S_WORD, S_LINECOM, S_BLOCK, S_BLOCK_OPEN, S_BLOCK_CLOSE, S_STR,
    S_STR_ESC, S_OP2, S_BIN, S_OCT, S_HEX, S_DEC, S_FRAC, S_PRE_B, S_PRE_X
  } scan_state_t;

  typedef struct {
    logic [7:0] c;
    logic       eos;
  } byte_item_t;

  typedef struct {
    logic [6:0]  kind;
    logic [23:0] start;
    logic [23:0] len;
    logic [19:0] line;
    logic [15:0] col;
    logic [7:0]  file;
    logic [1:0]  err;
    logic        last;
  } token_rec_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        end_of_source;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  token_kind;
  logic [23:0] start_offset;
  logic [23:0] lexeme_length;
  logic [19:0] line_number;
  logic [15:0] column_number;
  logic [7:0]  source_file;
  logic [1:0]  error_kind;
  logic        last_of_run;

  source_lexer_top u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
    .end_of_source(end_of_source), .out_valid(out_valid), .out_stall(out_stall),
    .token_kind(token_kind), .start_offset(start_offset),
    .lexeme_length(lexeme_length), .line_number(line_number),
    .column_number(column_number), .source_file(source_file),
    .error_kind(error_kind), .last_of_run(last_of_run)
  );

  byte_item_t  pending_bytes[$];
  token_rec_t  expected_tokens[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  // Lexer state as the testbench sees it.
  logic [7:0]  file_no;
  scan_state_t scan;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [23:0] pos;
  logic [23:0] tok_start;
  logic [19:0] line_no;
  logic [15:0] col_no;
  logic [63:0] prefix;
  logic [3:0]  wlen;
  token_rec_t  step_toks[3];
  int          step_n;

  string kw_names[21] = '{"and", "break", "case", "class", "continue", "default",
    "else", "false", "for", "fun", "if", "null", "or", "debug", "return",
    "super", "switch", "this", "true", "var", "while"};

  string pieces[$] = '{"and", "break", "case", "class", "continue", "default",
    "else", "false", "for", "fun", "if", "null", "or", "debug", "return",
    "super", "switch", "this", "true", "var", "while", "print", "continues",
    "abcdefghij", "x_1", "Z9", "0b1011", "0b", "0x", "0xfA9", "0777", "08", "0",
    "12.5", "7.", "3.a", "\"hi\"", "\"a\\\\\"", "\"q\\\"z\"", "\"\n\"", "//c !\n",
    "/*x*\n*/", "/**/", "/*/", "#inc <a>\n", " ", "\n", "\t", "\r", "-", "--",
    "-=", "+", "++", "+=", "/", "/=", "*", "*=", "~", "~=", "^", "^=", "&", "&=",
    "|", "|=", "%", "%=", "?", ":", "!", "!=", "=", "==", "<", "<=", "<<", ">",
    ">=", ">>", "(", ")", "{", "}", "[", "]", ";", ",", ".", "@", "$", "\""};

  function automatic logic letter_c(logic [8:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_c(logic [8:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic octal_c(logic [8:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic hex_c(logic [8:0] c);
    return digit_c(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic void clear_scan();
    scan = S_IDLE;
    held_byte = 8'd0;
    held_valid = 1'b0;
    pos = '0;
    tok_start = '0;
    line_no = 20'd1;
    col_no = 16'd1;
    prefix = '0;
    wlen = '0;
  endfunction

  function automatic void bump_col();
    if (col_no != 16'hFFFF) col_no++;
  endfunction

  function automatic void bump_line();
    if (line_no != 20'hFFFFF) line_no++;
    col_no = 16'd2;
  endfunction

  function automatic void add_token(logic [6:0] kind, logic [23:0] start,
                                    logic [23:0] len, logic [1:0] err);
    if (step_n < 3) begin
      step_toks[step_n] = '{kind, start, len, line_no, col_no, file_no, err, 1'b0};
      step_n++;
    end
  endfunction

  function automatic logic [6:0] classify_word();
    logic [63:0] p;
    logic [6:0]  k;
    k = K_IDENT;
    if (wlen <= 4'd8) begin
      for (int i = 0; i < 21; i++) begin
        p = '0;
        for (int j = 0; j < kw_names[i].len(); j++) p = (p << 8) | kw_names[i][j];
        if (kw_names[i].len() == wlen && p == prefix) k = K_KEYWORD0 + 7'(i);
      end
    end
    return k;
  endfunction

  function automatic void op_pair(logic [8:0] n, logic [8:0] a, logic [6:0] ak,
                                  logic [8:0] b, logic [6:0] bk, logic [6:0] one);
    bump_col();
    if (n == a) begin
      add_token(ak, pos, 24'd2, ERR_NONE);
      scan = S_OP2;
    end else if (n == b) begin
      add_token(bk, pos, 24'd2, ERR_NONE);
      scan = S_OP2;
    end else begin
      add_token(one, pos, 24'd1, ERR_NONE);
    end
  endfunction

  function automatic void start_lexeme(logic [7:0] c, logic [8:0] n);
    tok_start = pos;
    if (c == " " || c == "\r" || c == "\t") begin
      bump_col();
    end else if (c == "\n") begin
      bump_line();
    end else if (c == "#") begin
      bump_col();
      scan = S_LINECOM;
    end else if (letter_c(c)) begin
      bump_col();
      prefix = 64'(c);
      wlen = 4'd1;
      scan = S_WORD;
    end else if (digit_c(c)) begin
      bump_col();
      if (c == "0" && n == "b") scan = S_PRE_B;
      else if (c == "0" && octal_c(n)) scan = S_OCT;
      else if (c == "0" && n == "x") scan = S_PRE_X;
      else scan = S_DEC;
    end else if (c == "/" && n == "/") begin
      bump_col();
      scan = S_LINECOM;
    end else if (c == "/" && n == "*") begin
      bump_col();
      scan = S_BLOCK_OPEN;
    end else if (c == "\"") begin
      bump_col();
      scan = S_STR;
    end else begin
      case (c)
        "(": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd0);
        ")": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd1);
        "{": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd2);
        "}": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd3);
        "[": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd4);
        "]": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd5);
        ";": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd6);
        ",": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd7);
        ".": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd8);
        "-": op_pair(n, "-", 7'd10, "=", 7'd11, 7'd9);
        "+": op_pair(n, "+", 7'd13, "=", 7'd14, 7'd12);
        "/": op_pair(n, "=", K_SLASH_EQ, NO_PAIR, 0, K_SLASH);
        "*": op_pair(n, "=", 7'd18, NO_PAIR, 0, 7'd17);
        "~": op_pair(n, "=", 7'd20, NO_PAIR, 0, 7'd19);
        "^": op_pair(n, "=", 7'd22, NO_PAIR, 0, 7'd21);
        "&": op_pair(n, "=", 7'd24, NO_PAIR, 0, 7'd23);
        "|": op_pair(n, "=", 7'd26, NO_PAIR, 0, 7'd25);
        "%": op_pair(n, "=", 7'd28, NO_PAIR, 0, 7'd27);
        "?": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd29);
        ":": op_pair(n, NO_PAIR, 0, NO_PAIR, 0, 7'd30);
        "!": op_pair(n, "=", 7'd32, NO_PAIR, 0, 7'd31);
        "=": op_pair(n, "=", 7'd34, NO_PAIR, 0, 7'd33);
        "<": op_pair(n, "=", 7'd36, "<", 7'd37, 7'd35);
        ">": op_pair(n, "=", 7'd39, ">", 7'd40, 7'd38);
        default: begin
          bump_col();
          add_token(K_ERROR, pos, 24'd1, ERR_UNEXPECTED);
        end
      endcase
    end
  endfunction

  function automatic void judge_byte(logic [7:0] c, logic [8:0] n);
    logic [23:0] slen;
    case (scan)
      S_WORD: begin
        if (letter_c(c) || digit_c(c)) begin
          bump_col();
          if (wlen < 4'd8) prefix = (prefix << 8) | 64'(c);
          if (wlen < 4'd9) wlen++;
          return;
        end
        add_token(classify_word(), tok_start, pos - tok_start, ERR_NONE);
      end
      S_BIN: begin
        if (c == "0" || c == "1") begin
          bump_col();
          return;
        end
        add_token(K_BIN, tok_start, pos - tok_start, ERR_NONE);
      end
      S_OCT: begin
        if (octal_c(c)) begin
          bump_col();
          return;
        end
        add_token(K_OCT, tok_start, pos - tok_start, ERR_NONE);
      end
      S_HEX: begin
        if (hex_c(c)) begin
          bump_col();
          return;
        end
        add_token(K_HEX, tok_start, pos - tok_start, ERR_NONE);
      end
      S_DEC: begin
        if (digit_c(c)) begin
          bump_col();
          return;
        end
        if (c == "." && digit_c(n)) begin
          bump_col();
          scan = S_FRAC;
          return;
        end
        add_token(K_DEC, tok_start, pos - tok_start, ERR_NONE);
      end
      S_FRAC: begin
        if (digit_c(c)) begin
          bump_col();
          return;
        end
        add_token(K_DEC, tok_start, pos - tok_start, ERR_NONE);
      end
      S_PRE_B: begin
        bump_col();
        scan = S_BIN;
        return;
      end
      S_PRE_X: begin
        bump_col();
        scan = S_HEX;
        return;
      end
      S_LINECOM: begin
        if (c != "\n") begin
          bump_col();
          return;
        end
      end
      S_BLOCK: begin
        if (c == "*" && n == "/") begin
          bump_col();
          scan = S_BLOCK_CLOSE;
        end else if (c == "\n") begin
          bump_line();
        end else begin
          bump_col();
        end
        return;
      end
      S_BLOCK_OPEN: begin
        bump_col();
        scan = S_BLOCK;
        return;
      end
      S_BLOCK_CLOSE: begin
        bump_col();
        scan = S_IDLE;
        return;
      end
      S_STR: begin
        if (c == "\"") begin
          slen = pos - tok_start;
          bump_col();
          if (pos != 24'hFFFFFF) slen++;
          add_token(K_STRING, tok_start, slen, ERR_NONE);
          scan = S_IDLE;
        end else if (c == "\n") begin
          bump_line();
        end else begin
          bump_col();
          if (c == "\\" && (n == "\\" || n == "\"")) scan = S_STR_ESC;
        end
        return;
      end
      S_STR_ESC: begin
        bump_col();
        scan = S_STR;
        return;
      end
      S_OP2: begin
        scan = S_IDLE;
        return;
      end
      default: scan = S_IDLE;
    endcase
    scan = S_IDLE;
    start_lexeme(c, n);
  endfunction

  function automatic void close_source();
    case (scan)
      S_WORD: add_token(classify_word(), tok_start, pos - tok_start, ERR_NONE);
      S_BIN: add_token(K_BIN, tok_start, pos - tok_start, ERR_NONE);
      S_OCT: add_token(K_OCT, tok_start, pos - tok_start, ERR_NONE);
      S_HEX: add_token(K_HEX, tok_start, pos - tok_start, ERR_NONE);
      S_DEC, S_FRAC: add_token(K_DEC, tok_start, pos - tok_start, ERR_NONE);
      S_STR, S_STR_ESC: add_token(K_ERROR, tok_start, pos - tok_start, ERR_UNTERM_STR);
      default: step_n = step_n;
    endcase
    add_token(K_EOF, pos, 24'd0, ERR_NONE);
    clear_scan();
  endfunction

  function automatic void predict_tokens(byte_item_t it);
    step_n = 0;
    if (it.eos) begin
      if (held_valid) begin
        judge_byte(held_byte, NO_NEXT);
        if (pos != 24'hFFFFFF) pos++;
      end
      close_source();
    end else begin
      if (held_valid) begin
        judge_byte(held_byte, {1'b0, it.c});
        if (pos != 24'hFFFFFF) pos++;
      end
      held_byte = it.c;
      held_valid = 1'b1;
    end
    if (step_n > 0) step_toks[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_tokens.push_back(step_toks[i]);
  endfunction

  task automatic queue_byte(logic [7:0] b);
    byte_item_t it;
    it.c = b;
    it.eos = 1'b0;
    pending_bytes.push_back(it);
  endtask

  task automatic queue_text(string s, bit close);
    byte_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.c = s[i];
      it.eos = 1'b0;
      pending_bytes.push_back(it);
    end
    if (close) begin
      it.c = 8'($urandom_range(0, 255));
      it.eos = 1'b1;
      pending_bytes.push_back(it);
    end
  endtask

  task automatic queue_random_source();
    string s;
    int    r;
    s = "";
    repeat ($urandom_range(1, 10)) begin
      r = $urandom_range(0, 99);
      if (r < 85) s = {s, pieces[$urandom_range(0, pieces.size() - 1)]};
      else if (r < 92) s = {s, " "};
      else s = {s, string'(byte'($urandom_range(0, 255)))};
      if ($urandom_range(0, 1) == 1) s = {s, " "};
    end
    queue_text(s, 1'b1);
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_file_no(logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    file_no = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Input driver.
  always @(posedge clk) begin
    byte_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_tokens('{char_code, end_of_source});
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          char_code <= nxt.c;
          end_of_source <= nxt.eos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor.
  always @(posedge clk) begin
    token_rec_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected transaction: kind %0d", token_kind);
          fail_count++;
        end else begin
          e = expected_tokens.pop_front();
          check_field("token_kind", e.kind, token_kind);
          check_field("start_offset", e.start, start_offset);
          check_field("lexeme_length", e.len, lexeme_length);
          check_field("line_number", e.line, line_number);
          check_field("column_number", e.col, column_number);
          check_field("source_file", e.file, source_file);
          check_field("error_kind", e.err, error_kind);
          check_field("last_of_run", e.last, last_of_run);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = 8'd0;
    in_valid = 1'b0;
    char_code = 8'd0;
    end_of_source = 1'b0;
    out_stall = 1'b0;
    file_no = 8'd0;
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_text("0b1 017 0x1F 3.14 \"a\\\"b\" x>>=y", 1'b1);
    queue_byte(8'h00);
    queue_text({string'(byte'(8'hFF)), "#d\n\"ab"}, 1'b1);
    queue_text("/* a", 1'b1);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_file_no(8'd255);
        1: write_file_no(8'd0);
        default: write_file_no(8'($urandom_range(0, 255)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      while (pending_bytes.size() < 40) queue_random_source();
      if (ph == 5) begin
        while (pending_bytes.size() != 0) @(posedge clk);
        while (expected_tokens.size() != 0) @(posedge clk);
        while (pending_bytes.size() < 30) queue_random_source();
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
